// ===== src/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	// Width kept for the payload length (16..64)
	localparam int LENGTH_BITS = 64;

	// Seven-bit length codes that announce an extended length
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	// Extension and key byte counts
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [2:0] KEY_BYTES   = 3'd4;

	// Parser phase, one-hot
	typedef enum logic [4:0] {
		PH_HDR0 = 5'b00001,
		PH_HDR1 = 5'b00010,
		PH_EXT  = 5'b00100,
		PH_KEY  = 5'b01000,
		PH_DATA = 5'b10000
	} phase_t;

	// One result beat
	typedef struct packed {
		logic       empty_frame;
		logic [7:0] data_byte;
		logic       final_fragment;
		logic [3:0] frame_opcode;
		logic       first_of_frame;
		logic       last_of_frame;
	} res_t;

endpackage

// ===== src/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Byte-serial frame header parser and payload unmasker; one byte per beat.
// ----------------------------------------------------------------------------
module wsd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       stream_byte,
	output logic             res_valid,
	output wsd_pkg::res_t    res
);
	import wsd_pkg::*;

	phase_t                 phase_q,    phase_d;
	logic                   fin_q,      fin_d;
	logic [3:0]             opcode_q,   opcode_d;
	logic                   masked_q,   masked_d;
	logic [3:0]             ext_left_q, ext_left_d;
	logic [LENGTH_BITS-1:0] len_q,      len_d;
	logic [31:0]            key_q,      key_d;
	logic [2:0]             key_left_q, key_left_d;
	logic [1:0]             key_idx_q,  key_idx_d;
	logic [LENGTH_BITS-1:0] pay_left_q, pay_left_d;
	logic                   first_q,    first_d;

	logic [LENGTH_BITS-1:0] len_shift;
	logic [2:0]             key_left_dec;
	logic [3:0]             ext_left_dec;
	logic [7:0]             key_byte;
	logic                   pay_last;

	assign len_shift    = {len_q[LENGTH_BITS-9:0], stream_byte};
	assign ext_left_dec = (ext_left_q != 4'd0) ? ext_left_q - 4'd1 : 4'd0;
	assign key_left_dec = (key_left_q != 3'd0) ? key_left_q - 3'd1 : 3'd0;
	assign key_byte     = key_q[(2'd3 - key_idx_q) * 8 +: 8];
	// last byte once at most one remains (a zero count also ends the frame)
	assign pay_last     = (pay_left_q[LENGTH_BITS-1:1] == '0);

	// next state and result
	always_comb begin
		phase_d    = phase_q;
		fin_d      = fin_q;
		opcode_d   = opcode_q;
		masked_d   = masked_q;
		ext_left_d = ext_left_q;
		len_d      = len_q;
		key_d      = key_q;
		key_left_d = key_left_q;
		key_idx_d  = key_idx_q;
		pay_left_d = pay_left_q;
		first_d    = first_q;
		res_valid  = 1'b0;
		res        = '{empty_frame: 1'b1, data_byte: 8'd0, final_fragment: fin_q,
		               frame_opcode: opcode_q, first_of_frame: 1'b1,
		               last_of_frame: 1'b1};

		unique case (phase_q)
			PH_HDR1: begin
				masked_d = stream_byte[7];
				if (stream_byte[6:0] == LEN_CODE_EXT16) begin
					len_d      = '0;
					ext_left_d = EXT16_BYTES;
					phase_d    = PH_EXT;
				end else if (stream_byte[6:0] == LEN_CODE_EXT64) begin
					len_d      = '0;
					ext_left_d = EXT64_BYTES;
					phase_d    = PH_EXT;
				end else begin
					len_d = {{(LENGTH_BITS-7){1'b0}}, stream_byte[6:0]};
					if (stream_byte[7]) begin
						key_left_d = KEY_BYTES;
						phase_d    = PH_KEY;
					end else begin
						pay_left_d = len_d;
						key_idx_d  = 2'd0;
						if (stream_byte[6:0] == 7'd0) begin
							res_valid = 1'b1;
							first_d   = 1'b1;
							phase_d   = PH_HDR0;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
			end
			PH_EXT: begin
				len_d      = len_shift;
				ext_left_d = ext_left_dec;
				if (ext_left_dec == 4'd0) begin
					if (masked_q) begin
						key_left_d = KEY_BYTES;
						phase_d    = PH_KEY;
					end else begin
						pay_left_d = len_shift;
						key_idx_d  = 2'd0;
						if (len_shift == '0) begin
							res_valid = 1'b1;
							first_d   = 1'b1;
							phase_d   = PH_HDR0;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
			end
			PH_KEY: begin
				key_d      = {key_q[23:0], stream_byte};
				key_left_d = key_left_dec;
				if (key_left_dec == 3'd0) begin
					pay_left_d = len_q;
					key_idx_d  = 2'd0;
					if (len_q == '0) begin
						res_valid = 1'b1;
						first_d   = 1'b1;
						phase_d   = PH_HDR0;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				key_idx_d  = key_idx_q + 2'd1;
				pay_left_d = (pay_left_q != '0) ? pay_left_q - LENGTH_BITS'(1) : '0;
				res_valid  = 1'b1;
				res.empty_frame    = 1'b0;
				res.data_byte      = stream_byte ^ key_byte;
				res.first_of_frame = first_q;
				res.last_of_frame  = pay_last;
				first_d = pay_last;
				if (pay_last) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				// first header byte; RSV bits dropped
				fin_d     = stream_byte[7];
				opcode_d  = stream_byte[3:0];
				masked_d  = 1'b0;
				key_d     = '0;
				key_idx_d = 2'd0;
				first_d   = 1'b1;
				phase_d   = PH_HDR1;
			end
		endcase
	end

	// state update on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			fin_q      <= 1'b0;
			opcode_q   <= 4'd0;
			masked_q   <= 1'b0;
			ext_left_q <= 4'd0;
			len_q      <= '0;
			key_q      <= '0;
			key_left_q <= 3'd0;
			key_idx_q  <= 2'd0;
			pay_left_q <= '0;
			first_q    <= 1'b1;
		end else if (take) begin
			phase_q    <= phase_d;
			fin_q      <= fin_d;
			opcode_q   <= opcode_d;
			masked_q   <= masked_d;
			ext_left_q <= ext_left_d;
			len_q      <= len_d;
			key_q      <= key_d;
			key_left_q <= key_left_d;
			key_idx_q  <= key_idx_d;
			pay_left_q <= pay_left_d;
			first_q    <= first_d;
		end
	end

endmodule

// ===== src/wsd_out_buf.sv =====
// ----------------------------------------------------------------------------
// wsd_out_buf
// Result register with a skid stage, so the input side keeps going while a
// result waits.
// ----------------------------------------------------------------------------
module wsd_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wsd_pkg::res_t push_data,
	output logic          full,
	output logic          out_valid,
	input  logic          out_stall,
	output wsd_pkg::res_t out_data
);
	import wsd_pkg::*;

	logic main_valid_q;
	res_t main_q;
	logic skid_valid_q;
	res_t skid_q;
	logic main_free;

	assign main_free = !main_valid_q || !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// control: skid is only filled while the main register is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ===== src/websocket_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Deframes WebSocket frames from a byte stream and emits unmasked payload
// bytes with frame marks, or one marker beat for an empty frame.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  input   | in        | in_valid / in_stall | stream_byte
//  output  | out       | out_valid/out_stall | empty_frame, data_byte,
//          |           |                     | final_fragment, frame_opcode,
//          |           |                     | first_of_frame, last_of_frame
//
// One byte is taken every cycle while in_stall is low. Parser state, result
// register and its skid stage are the only stages; results are registered.
// Reset (arst_n low) returns the parser to the first header byte.
// in_stall rises only when both the result register and its skid stage hold
// beats; it does not depend on in_valid.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] stream_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       empty_frame,
	output logic [7:0] data_byte,
	output logic       final_fragment,
	output logic [3:0] frame_opcode,
	output logic       first_of_frame,
	output logic       last_of_frame
);
	import wsd_pkg::*;

	logic take;
	logic res_valid;
	res_t res;
	logic buf_full;
	res_t out_res;

	assign in_stall = buf_full;
	assign take     = in_valid && !buf_full;

	wsd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.stream_byte (stream_byte),
		.res_valid   (res_valid),
		.res         (res)
	);

	wsd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	// result fields onto their ports
	assign empty_frame    = out_res.empty_frame;
	assign data_byte      = out_res.data_byte;
	assign final_fragment = out_res.final_fragment;
	assign frame_opcode   = out_res.frame_opcode;
	assign first_of_frame = out_res.first_of_frame;
	assign last_of_frame  = out_res.last_of_frame;

endmodule
